// ----- rtl/core/sld_pkg.sv -----
// shared constants, types and command/status structs of the serial length frame deframer
package sld_pkg;

  localparam int PACKET_BYTES = 64;
  localparam int ADDR_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int CNT_W = $clog2(PACKET_BYTES + 1);

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] TRAILER_BYTE = 8'hFE;
  localparam logic [7:0] MAX_LEN_BYTE = 8'(PACKET_BYTES);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_PAY,
    ST_RD,
    ST_SEND
  } sld_state_t;

  typedef struct packed {
    logic clear_cnt;
    logic load_len;
    logic wr_en;
    logic emit_start;
    logic rd_en;
    logic idx_inc;
  } sld_cmd_t;

  typedef struct packed {
    logic is_header;
    logic len_bad;
    logic at_trailer;
    logic good_trailer;
    logic idx_last;
  } sld_status_t;

endpackage

// ----- rtl/core/sld_ram.sv -----
// generic single write port, single read port ram with registered read
module sld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/sld_dpath.sv -----
// datapath: byte decode, length and fill counters, packet store and read index
module sld_dpath
  import sld_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  sld_cmd_t            cmd,
  output sld_status_t         status,
  input  logic [7:0]          rx_byte,
  input  logic                host_ready,
  output logic [7:0]          packet_byte,
  output logic                packet_last
);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [7:0]        rd_data;

  // fill count marks which store entries belong to the current frame
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear_cnt) begin
      cnt_nxt = '0;
    end else if (cmd.wr_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (cmd.load_len) begin
      len_nxt = rx_byte[CNT_W-1:0];
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.emit_start) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      len_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
      idx_r <= idx_nxt;
    end
  end

  sld_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (rx_byte),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  always_comb begin
    status.is_header    = (rx_byte == HEADER_BYTE);
    status.len_bad      = (rx_byte > MAX_LEN_BYTE);
    status.at_trailer   = (cnt_r >= len_r);
    status.good_trailer = (rx_byte == TRAILER_BYTE) && host_ready;
    status.idx_last     = (idx_r == ADDR_W'(PACKET_BYTES - 1));
  end

  // entries past the fill count were not written this frame and read as zero
  assign packet_byte = (CNT_W'(idx_r) < cnt_r) ? rd_data : 8'h00;
  assign packet_last = status.idx_last;

endmodule

// ----- rtl/core/sld_ctrl.sv -----
// controller: frame parse and packet drain state machine
module sld_ctrl
  import sld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  sld_status_t status,
  output sld_cmd_t    cmd
);

  sld_state_t state_r, state_nxt;
  logic       in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    in_acc    = 1'b0;
    case (state_r)
      ST_HUNT: begin
        in_stall = 1'b0;
        in_acc   = in_valid;
        if (in_acc && status.is_header) begin
          cmd.clear_cnt = 1'b1;
          state_nxt     = ST_LEN;
        end
      end
      ST_LEN: begin
        in_stall = 1'b0;
        in_acc   = in_valid;
        if (in_acc) begin
          if (status.len_bad) begin
            state_nxt = ST_HUNT;
          end else begin
            cmd.load_len = 1'b1;
            state_nxt    = ST_PAY;
          end
        end
      end
      ST_PAY: begin
        in_stall = 1'b0;
        in_acc   = in_valid;
        if (in_acc) begin
          if (!status.at_trailer) begin
            cmd.wr_en = 1'b1;
          end else if (status.good_trailer) begin
            cmd.emit_start = 1'b1;
            state_nxt      = ST_RD;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (status.idx_last) begin
            state_nxt = ST_HUNT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_input_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a packet is draining");

  a_next_byte_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !status.idx_last) |=> (state_r == ST_RD))
    else $error("next packet byte not fetched after transaction");

  a_last_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && status.idx_last) |=> (!out_valid && !in_stall))
    else $error("packet drain did not end after last byte");

  a_write_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (!status.at_trailer && state_r == ST_PAY))
    else $error("store written outside payload");
`endif

endmodule

// ----- rtl/core/serial_length_frame_deframer.sv -----
// top level of the serial length frame deframer: controller plus datapath
// after a good trailer transaction the store is read in ST_RD, then ST_SEND offers the first packet byte
// throughput: header, length and payload bytes are taken one per cycle
// a packet drains one byte at a time (store read in ST_RD, then send in ST_SEND), PACKET_BYTES bytes in all
// input is stalled while the packet drains; output stalls stretch the drain
// reset: synchronous active low, parser back to header hunt, store not cleared
module serial_length_frame_deframer
  import sld_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel, one serial byte per transaction
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_host_ready,
  // result channel, one packet byte per transaction
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_packet_byte,
  output logic       out_packet_last
);

  // command and status between controller and datapath
  sld_cmd_t    cmd;
  sld_status_t status;

  // state machine: header hunt, length, payload/trailer, then read/send loop
  sld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // counters, packet store and byte decode
  // unwritten store entries read as zero via the fill count, so no clearing pass
  sld_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .rx_byte     (in_rx_byte),
    .host_ready  (in_host_ready),
    .packet_byte (out_packet_byte),
    .packet_last (out_packet_last)
  );

endmodule

// ----- verif/deframer_checker.sv -----
`timescale 1ns / 100ps
// packet predictor and byte-by-byte packet checker for the serial length frame deframer
module deframer_checker
  import sld_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_host_ready,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_packet_byte,
  input  logic       out_packet_last,
  output int         fail_count,
  output int         pending_count,
  output int         bytes_taken,
  output int         packets_done,
  output int         frames_dropped
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packet_beat_t;

  packet_beat_t expected_beats[$];

  // predicted parser state
  logic       frame_open;
  logic [6:0] byte_pos;
  logic [6:0] pay_len;
  logic [7:0] pkt_store [PACKET_BYTES];

  int mismatches = 0;
  int rx_seen = 0;
  int packets_seen = 0;
  int frames_lost = 0;

  initial begin
    frame_open = 1'b0;
    byte_pos = '0;
    pay_len = '0;
    foreach (pkt_store[i]) pkt_store[i] = '0;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatches < 30)
      $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $time);
    mismatches++;
  endtask

  // one serial byte through the predicted parser, queuing a whole packet on a good trailer
  task automatic deframe_byte(input logic [7:0] rx, input logic ready);
    logic [6:0] offset;
    packet_beat_t beat;
    rx_seen++;
    if (!frame_open) begin
      if (rx == HEADER_BYTE) begin
        frame_open = 1'b1;
        foreach (pkt_store[i]) pkt_store[i] = '0;
      end
      byte_pos = '0;
    end else if (byte_pos == '0) begin
      if (rx > MAX_LEN_BYTE) begin
        frame_open = 1'b0;
        frames_lost++;
      end else begin
        pay_len = rx[6:0];
        byte_pos = 7'd1;
      end
    end else begin
      offset = byte_pos - 7'd1;
      if (offset >= pay_len) begin
        if (rx == TRAILER_BYTE && ready) begin
          for (int k = 0; k < PACKET_BYTES; k++) begin
            beat.data = pkt_store[k];
            beat.last = (k == PACKET_BYTES - 1);
            expected_beats.push_back(beat);
          end
        end else begin
          frames_lost++;
        end
        frame_open = 1'b0;
        byte_pos = '0;
      end else begin
        pkt_store[offset[ADDR_W-1:0]] = rx;
        byte_pos = byte_pos + 7'd1;
      end
    end
  endtask

  task automatic check_beat(input logic [7:0] data, input logic last);
    packet_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("packet byte with no packet pending", 0, 32'(data));
    end else begin
      want = expected_beats.pop_front();
      if (data !== want.data) report_mismatch("packet_byte", 32'(want.data), 32'(data));
      if (last !== want.last) report_mismatch("packet_last", 32'(want.last), 32'(last));
      if (want.last) packets_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) check_beat(out_packet_byte, out_packet_last);
      if (in_valid === 1'b1 && in_stall === 1'b0) deframe_byte(in_rx_byte, in_host_ready);
    end
    fail_count <= mismatches;
    pending_count <= expected_beats.size();
    bytes_taken <= rx_seen;
    packets_done <= packets_seen;
    frames_dropped <= frames_lost;
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// top of the deframer testbench: clock, reset, serial stimulus, receiver stalls and verdict
module testbench
  import sld_pkg::*;
();

  localparam int RANDOM_ITEMS = 420;                 // frame bytes in the random part
  localparam int HOLD_CYCLES = 400;                  // one long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;              // cycles with no transaction at all
  localparam int TAIL_CYCLES = 2 * PACKET_BYTES + 16; // one full drain plus margin

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       in_host_ready;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_packet_byte;
  logic       out_packet_last;

  int fail_count;
  int pending_count;
  int bytes_taken;
  int packets_done;
  int frames_dropped;

  int frame_bytes = 0;   // bytes sent inside random frames, noise excluded
  int frames_sent = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;    // both sides run back to back while set
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always #5 clk = ~clk;

  serial_length_frame_deframer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_host_ready  (in_host_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_packet_byte(out_packet_byte),
    .out_packet_last(out_packet_last)
  );

  deframer_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_host_ready  (in_host_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_packet_byte(out_packet_byte),
    .out_packet_last(out_packet_last),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .bytes_taken    (bytes_taken),
    .packets_done   (packets_done),
    .frames_dropped (frames_dropped)
  );

  // idle stretch length: mostly a few cycles, now and then a long one
  function automatic int idle_span();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 50);
  endfunction

  // offer one serial byte, with an optional idle gap first, and wait for the transaction
  task automatic put_byte(input logic [7:0] rx, input logic ready);
    int gap;
    gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= rx;
    in_host_ready <= ready;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // one random frame; with clean set it is short, complete and always delivered
  task automatic send_frame(input bit clean);
    int pick;
    int plen;
    int cut;
    logic [7:0] b;
    // leading noise while idle, sometimes a stray header that breaks the frame
    if (!clean && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if (clean) plen = $urandom_range(0, 4);
    else if (frames_sent == 4 || pick < 3) plen = PACKET_BYTES;
    else if (pick < 8) plen = $urandom_range(PACKET_BYTES + 1, 255);
    else if (pick < 12) plen = $urandom_range(PACKET_BYTES - 8, PACKET_BYTES);
    else plen = $urandom_range(0, 6);
    frames_sent++;
    put_byte(HEADER_BYTE, 1'($urandom_range(0, 1)));
    put_byte(8'(plen), 1'($urandom_range(0, 1)));
    frame_bytes += 2;
    if (plen <= PACKET_BYTES) begin
      // now and then the frame is cut short and the next header lands in the payload
      cut = (!clean && $urandom_range(0, 19) == 0) ? $urandom_range(0, plen) : plen;
      for (int i = 0; i < cut; i++) begin
        pick = $urandom_range(0, 7);
        b = (pick == 0) ? HEADER_BYTE : (pick == 1) ? TRAILER_BYTE : 8'($urandom_range(0, 255));
        put_byte(b, 1'($urandom_range(0, 1)));
        frame_bytes++;
      end
      if (cut == plen) begin
        if (clean) put_byte(TRAILER_BYTE, 1'b1);
        else put_byte(($urandom_range(0, 99) < 85) ? TRAILER_BYTE : 8'($urandom_range(0, 255)),
                      $urandom_range(0, 99) < 85);
        frame_bytes++;
      end
    end
  endtask

  // receiver side: random stalls, quiet stretches and one long hold-off
  initial begin
    logic stall_now;
    int span;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        // long hold-off: a packet backs up and the input gets stalled
        hold_done = 1'b1;
        stall_now = 1'b1;
        span = HOLD_CYCLES;
      end else if (no_idle) begin
        stall_now = 1'b0;
        span = 4;
      end else begin
        stall_now = ($urandom_range(0, 2) == 0);
        span = stall_now ? idle_span() : $urandom_range(1, 6);
      end
      out_stall <= stall_now;
      repeat (span) @(posedge clk);
    end
  end

  // watchdog: any cycle without a transaction on either channel counts toward the limit
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= '0;
    in_host_ready <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle noise, including a bare trailer value, is ignored
    put_byte(8'h00, 1'b1);
    put_byte(TRAILER_BYTE, 1'b1);
    // empty frame: length zero, trailer right away, packet of all zeros
    put_byte(HEADER_BYTE, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(TRAILER_BYTE, 1'b1);
    // length one above the packet size aborts
    put_byte(HEADER_BYTE, 1'b1);
    put_byte(MAX_LEN_BYTE + 8'd1, 1'b1);
    // header value as the length byte is too long and aborts too
    put_byte(HEADER_BYTE, 1'b1);
    put_byte(HEADER_BYTE, 1'b1);
    // a header value inside the payload is plain data
    put_byte(HEADER_BYTE, 1'b0);
    put_byte(8'h02, 1'b1);
    put_byte(HEADER_BYTE, 1'b0);
    put_byte(8'h80, 1'b1);
    put_byte(TRAILER_BYTE, 1'b1);
    // bad trailer drops the frame
    put_byte(HEADER_BYTE, 1'b1);
    put_byte(8'h01, 1'b1);
    put_byte(8'h55, 1'b0);
    put_byte(8'h12, 1'b1);
    // good trailer with the host link down drops the frame
    put_byte(HEADER_BYTE, 1'b1);
    put_byte(8'h01, 1'b1);
    put_byte(8'hAA, 1'b1);
    put_byte(TRAILER_BYTE, 1'b0);

    // random frames; every third stretch of about 90 bytes runs without idling
    while (frame_bytes < RANDOM_ITEMS) begin
      no_idle = ((frame_bytes / 90) % 3 == 2);
      if (!hold_req && frame_bytes >= 150) begin
        hold_req = 1'b1;
        send_frame(1'b1);
      end else begin
        send_frame(1'b0);
      end
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    // let the last packets drain, then watch a while for stray packet bytes
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d serial bytes in %0d random frames plus directed cases", bytes_taken,
             frames_sent);
    $display("%0d packets checked byte by byte, %0d frames aborted or dropped", packets_done,
             frames_dropped);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
